// ===== rtl/core/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared widths, request and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Default capacity of the deque.
  localparam int DEPTH_DEF = 8;

  // Payload widths of the request and response beats.
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 31;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NEG   = 2'd3;

  // Value reported for front and back when the deque is empty.
  localparam logic signed [VALUE_W-1:0] EMPTY_MARK = -32'sd1;

  // Request sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } bdq_state_t;

endpackage

// ===== rtl/core/bdq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------

// Request channel: operation and value to push.
interface bdq_in_if import bdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// Response channel: status, peeks and count after the request.
interface bdq_out_if import bdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  front_value;
  logic signed [VALUE_W-1:0]  back_value;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output status, output front_value, output back_value,
                  output count, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input count, output ready);
endinterface

// ===== rtl/core/bounded_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque
// Double-ended queue of non-negative values kept as a ring in a RAM.
// ----------------------------------------------------------------------------
// Each request beat pushes or pops at either end and yields one response beat
// with a status, the front and back values after the request (-1 when empty)
// and the entry count. The accept cycle updates head and count and writes a
// pushed value, the next cycle reads the front and back entries from the
// RAM, and S_RESP then loads the response register once the register is
// empty or being read; the entry RAM reads are registered. A request is
// accepted only after the previous response has been loaded. A response
// waiting in the output register does not block the next request beat.
module bounded_deque import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_req,
  bdq_out_if.source out_rsp
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Ring index add with one wrap correction; both operands are below DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] offs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  bdq_state_t state_r, state_nxt;

  logic [AW-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic               accept;
  logic               load_out;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr_front;
  logic [AW-1:0]      rd_addr_back;
  logic [ENTRY_W-1:0] rd_front;
  logic [ENTRY_W-1:0] rd_back;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic signed [VALUE_W-1:0] out_front_r;
  logic signed [VALUE_W-1:0] out_back_r;
  logic [COUNT_W-1:0]        out_count_r;

  assign accept = in_req.valid && in_req.ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_req.ready = 1'b0;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_RESP: begin
        load_out = !out_valid_r || out_rsp.ready;
      end
      default: begin
        in_req.ready = 1'b0;
      end
    endcase
  end

  // Request decode: status, new head and count, and the RAM write.
  always_comb begin
    status_nxt = STAT_OK;
    head_nxt   = head_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = ring_add(head_r, AW'(count_r));
    case (in_req.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (count_r >= CNT_W'(DEPTH)) begin
          status_nxt = STAT_FULL;
        end else if (in_req.push_value[VALUE_W-1]) begin
          status_nxt = STAT_NEG;
        end else begin
          count_nxt = count_r + 1'b1;
          wr_en     = accept;
          if (in_req.req_type == REQ_PUSH_FRONT) begin
            head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
            wr_addr  = head_nxt;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (count_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          if (in_req.req_type == REQ_POP_FRONT) begin
            head_nxt = ring_add(head_r, AW'(1));
          end
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  // Peek addresses from the updated head and count.
  assign rd_addr_front = head_r;
  assign rd_addr_back  = ring_add(head_r, AW'(count_r - 1'b1));

  // Entry storage.
  bdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_req.push_value[ENTRY_W-1:0]),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_front),
    .rd_addr_b (rd_addr_back),
    .rd_data_a (rd_front),
    .rd_data_b (rd_back)
  );

  // Control state: sequencer, head index and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Status of the request in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // Response register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Response payload; an empty deque reports the empty mark on both ends.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(count_r);
      if (count_r == '0) begin
        out_front_r <= EMPTY_MARK;
        out_back_r  <= EMPTY_MARK;
      end else begin
        out_front_r <= {1'b0, rd_front};
        out_back_r  <= {1'b0, rd_back};
      end
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.front_value = out_front_r;
  assign out_rsp.back_value  = out_back_r;
  assign out_rsp.count       = out_count_r;

endmodule

// ===== rtl/core/bdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque entry RAM
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque testbench
// Drives push and pop requests through the request channel and checks every
// response beat against a cycle-free model of the ring-buffer deque. The
// directed tests cover empty pops, negative pushes, filling to capacity and
// draining. The random traffic swings between filling and draining so that
// the full and empty boundaries are crossed often. Both channels stall at
// random, except during one long stretch with no stalls.
// ----------------------------------------------------------------------------
module tb;
  import bdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int RANDOM_REQS = 1650;
  localparam int STALL_PCT   = 13;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 10;

  // One response beat as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        count;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque #(
    .DEPTH(DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_rsp(out_ch)
  );

  // Model state of the deque.
  logic [ENTRY_W-1:0] slot_mem [DEPTH];
  int                 head_pos = 0;
  int                 fill_cnt = 0;

  rsp_beat_t pending_rsp [$];
  rsp_beat_t want_rsp;
  int        err_cnt   = 0;
  int        idle_cyc  = 0;
  bit        stall_on  = 1'b1;

  // 10 ns clock.
  always #5 clk = ~clk;

  // Compute the response of one accepted request and advance the model.
  task automatic predict_request(input logic [REQ_W-1:0] op, input logic [VALUE_W-1:0] raw);
    rsp_beat_t rsp;
    logic      neg;
    rsp.status = STAT_OK;
    neg = raw[VALUE_W-1];
    if (op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK) begin
      if (fill_cnt >= DEPTH) begin
        // A full deque refuses before the sign is looked at.
        rsp.status = STAT_FULL;
      end else if (neg) begin
        rsp.status = STAT_NEG;
      end else if (op == REQ_PUSH_FRONT) begin
        head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
        slot_mem[head_pos] = raw[ENTRY_W-1:0];
        fill_cnt++;
      end else begin
        slot_mem[(head_pos + fill_cnt) % DEPTH] = raw[ENTRY_W-1:0];
        fill_cnt++;
      end
    end else begin
      if (fill_cnt == 0) begin
        rsp.status = STAT_EMPTY;
      end else begin
        if (op == REQ_POP_FRONT) head_pos = (head_pos + 1) % DEPTH;
        fill_cnt--;
      end
    end
    if (fill_cnt == 0) begin
      rsp.front_value = EMPTY_MARK;
      rsp.back_value  = EMPTY_MARK;
    end else begin
      rsp.front_value = {1'b0, slot_mem[head_pos]};
      rsp.back_value  = {1'b0, slot_mem[(head_pos + fill_cnt - 1) % DEPTH]};
    end
    rsp.count = fill_cnt[COUNT_W-1:0];
    pending_rsp.push_back(rsp);
  endtask

  // Send one request beat, with an optional random gap before it.
  task automatic send_request(input logic [REQ_W-1:0] op, input logic [VALUE_W-1:0] raw);
    @(negedge clk);
    while (stall_on && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= op;
    in_ch.push_value <= raw;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(op, raw);
  endtask

  // Stop sending and wait until every predicted response has arrived.
  task automatic wait_for_responses();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Pops on an empty deque, with pop values that must be ignored.
  task automatic test_empty_pops();
    send_request(REQ_POP_FRONT, $urandom);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
  endtask

  // Negative values are refused at both ends.
  task automatic test_negative_pushes();
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity from both ends, then push into the full deque.
  task automatic test_fill_to_full();
    send_request(REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h5555_5555);
    send_request(REQ_PUSH_BACK, 32'h2AAA_AAAA);
    send_request(REQ_PUSH_FRONT, 32'h0000_0001);
    send_request(REQ_PUSH_BACK, 32'h4000_0000);
    // Full and negative at once: the full status wins.
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'h1234_5678);
  endtask

  // Drain from alternating ends, then pop once more on the empty deque.
  task automatic test_drain();
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
    end
    send_request(REQ_POP_FRONT, 32'h7FFF_FFFF);
    wait_for_responses();
  endtask

  // Random traffic that swings between filling and draining.
  task automatic test_random_traffic(input int n_reqs);
    bit               draining;
    int               pick;
    logic [REQ_W-1:0] op;
    logic [VALUE_W-1:0] raw;
    draining = 1'b0;
    for (int i = 0; i < n_reqs; i++) begin
      // A long stretch with no stalls on either side.
      stall_on = !(i >= n_reqs / 3 && i < n_reqs / 2);
      if (i == (2 * n_reqs) / 3) wait_for_responses();

      if (fill_cnt >= DEPTH) draining = 1'b1;
      else if (fill_cnt == 0) draining = 1'b0;
      else if ($urandom_range(99) < 4) draining = !draining;

      pick = $urandom_range(99);
      if (pick < 5) begin
        // Noise: any operation with any value.
        op  = REQ_W'($urandom_range(3));
        raw = $urandom;
      end else begin
        if ((draining && pick < 30) || (!draining && pick >= 30)) begin
          op = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
          case ($urandom_range(9))
            0: raw = 32'h0000_0000;
            1: raw = 32'h7FFF_FFFF;
            2: raw = {1'b1, 31'($urandom)};
            default: raw = {1'b0, 31'($urandom)};
          endcase
        end else begin
          op  = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
          raw = $urandom;
        end
      end
      send_request(op, raw);
    end
    stall_on = 1'b1;
  endtask

  // Response ready with random stalls, changed at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !(stall_on && $urandom_range(99) < STALL_PCT);
    end
  end

  // Compare each response beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response beat: status %0d front %0d back %0d count %0d",
                 $time, out_ch.status, out_ch.front_value, out_ch.back_value, out_ch.count);
        err_cnt++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (out_ch.status !== want_rsp.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want_rsp.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.front_value !== want_rsp.front_value) begin
          $display("%0t: front_value mismatch: expected %0d, actual %0d",
                   $time, want_rsp.front_value, out_ch.front_value);
          err_cnt++;
        end
        if (out_ch.back_value !== want_rsp.back_value) begin
          $display("%0t: back_value mismatch: expected %0d, actual %0d",
                   $time, want_rsp.back_value, out_ch.back_value);
          err_cnt++;
        end
        if (out_ch.count !== want_rsp.count) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want_rsp.count, out_ch.count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without a beat on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc + 1 >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d responses outstanding",
                 $time, pending_rsp.size());
        $display("** bounded_deque: FAILED **");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_PUSH_FRONT;
    in_ch.push_value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_negative_pushes();
    test_fill_to_full();
    test_drain();
    test_random_traffic(RANDOM_REQS);

    wait_for_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** bounded_deque: PASSED **");
    end else begin
      $display("** bounded_deque: FAILED **");
    end
    $finish;
  end

endmodule
